FILE: hw/rtl/shd_pkg.sv
// Shared types and constants for the strip hit detector with HIP suppression.
package shd_pkg;

	// Fine steps that make up one bunch clock.
	localparam int unsigned STEPS_PER_CLOCK = 25;
	localparam int unsigned STEP_W = $clog2(STEPS_PER_CLOCK);

	// Field and register widths.
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned THR_W    = 10;
	localparam int unsigned BLIND_W  = 5;
	localparam int unsigned LIMIT_W  = 4;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned CFG_W    = 10;
	localparam int unsigned IDX_W    = 2;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 8;

	// Run counter saturation value.
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Register reset values.
	localparam logic [THR_W-1:0]   THRESHOLD_RST   = THR_W'(20);
	localparam logic [BLIND_W-1:0] BLIND_STEPS_RST = BLIND_W'(3);
	localparam logic [LIMIT_W-1:0] HIP_LIMIT_RST   = LIMIT_W'(1);

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_THRESHOLD   = 2'd0,
		REG_BLIND_STEPS = 2'd1,
		REG_HIP_LIMIT   = 2'd2
	} reg_idx_t;

	// Current configuration as seen by the detector.
	typedef struct packed {
		logic [THR_W-1:0]   threshold;
		logic [BLIND_W-1:0] blind_steps;
		logic [LIMIT_W-1:0] hip_limit;
	} cfg_t;

	// One result item, lowest bit last.
	typedef struct packed {
		logic or_hip_hit;
		logic sampled_hip_hit;
		logic or_hit;
		logic latched_hit;
		logic sampled_hit;
	} result_t;

endpackage

FILE: hw/rtl/strip_hit_detect_hip_suppress.sv
// Top level of the strip hit detector with HIP suppression.
//
// One shaped sample is accepted every cycle unless input stalls; a result item appears once per
// bunch clock, on the last of its STEPS_PER_CLOCK fine steps (25 samples), and is registered
// from that sample. The sample passes an input register, then the per-step state and the result
// register, so the rate is set by the single state update per sample. A result waiting in the
// output register does not stop input; input stalls only when a new result is due and the
// previous one has not been taken. Configuration writes take effect on the next sample.
module strip_hit_detect_hip_suppress (
	input  logic                               clk,
	input  logic                               arst_n,
	// Sample stream. tdata: sample_value[11:0], zeros above.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [shd_pkg::IN_TDATA_W-1:0]     s_tdata,
	// Result stream. tdata: sampled_hit, latched_hit, or_hit, sampled_hip_hit,
	// or_hip_hit from bit 0 up, zeros above.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [shd_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// Configuration write port.
	input  logic                               cfg_wen,
	input  logic [shd_pkg::IDX_W-1:0]          cfg_index,
	input  logic [shd_pkg::CFG_W-1:0]          cfg_wdata
);
	import shd_pkg::*;

	cfg_t                       cfg_q;
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       out_valid_q;
	result_t                    out_result_q;

	logic    emit;
	result_t result;
	logic    out_free;
	logic    advance;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= THRESHOLD_RST;
			cfg_q.blind_steps <= BLIND_STEPS_RST;
			cfg_q.hip_limit   <= HIP_LIMIT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_THRESHOLD:   cfg_q.threshold   <= cfg_wdata[THR_W-1:0];
				REG_BLIND_STEPS: cfg_q.blind_steps <= cfg_wdata[BLIND_W-1:0];
				REG_HIP_LIMIT:   cfg_q.hip_limit   <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// The held sample advances unless it produces a result with nowhere to go.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= $signed(s_tdata[SAMPLE_W-1:0]);
		end
	end

	shd_detect u_detect (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.sample  (sample_s1),
		.cfg     (cfg_q),
		.emit    (emit),
		.result  (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_result_q);

`ifndef SYNTH
	// A suppressed hit can only come from a real hit.
	a_samp_hip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[3] || m_tdata[0]))
		else $error("sampled HIP hit without sampled hit");

	a_or_hip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[4] || m_tdata[2]))
		else $error("OR HIP hit without OR hit");

	// The OR hit combines the sampled and latched hits.
	a_or_comb: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2] == (m_tdata[0] | m_tdata[1])))
		else $error("OR hit inconsistent");

	// A held sample that cannot advance is not lost.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stalled sample dropped");
`endif

endmodule

FILE: hw/rtl/shd_detect.sv
// Per-step hit detection, edge latching and HIP run counters.
module shd_detect (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   step_en,
	input  logic signed [shd_pkg::SAMPLE_W-1:0]    sample,
	input  shd_pkg::cfg_t                          cfg,
	output logic                                   emit,
	output shd_pkg::result_t                       result
);
	import shd_pkg::*;

	logic [STEP_W-1:0] fine_step_q;
	logic              prev_comp_q;
	logic              sampled_flag_q;
	logic              latched_pending_q;
	logic              latched_current_q;
	logic [CNT_W-1:0]  sampled_run_count_q;
	logic [CNT_W-1:0]  or_run_count_q;

	logic comp;
	logic past_blind;
	logic edge_hit;
	logic samp_now;
	logic pending_next;
	logic or_now;

	// Signed compare of the sample against the zero-extended threshold.
	assign comp = sample > $signed({{(SAMPLE_W-THR_W){1'b0}}, cfg.threshold});

	// Rising edge outside the blind window, also across clock boundaries.
	assign past_blind   = 32'(fine_step_q) >= 32'(cfg.blind_steps);
	assign edge_hit     = past_blind && comp && !prev_comp_q;
	assign pending_next = latched_pending_q | edge_hit;

	// The sampled hit is the comparator at the first fine step.
	assign samp_now = (fine_step_q == '0) ? comp : sampled_flag_q;
	assign or_now   = samp_now | latched_current_q;
	assign emit     = fine_step_q == STEP_W'(STEPS_PER_CLOCK - 1);

	// Suppression is judged on the run count before this clock's update.
	always_comb begin
		result.sampled_hit     = samp_now;
		result.latched_hit     = latched_current_q;
		result.or_hit          = or_now;
		result.sampled_hip_hit = samp_now;
		result.or_hip_hit      = or_now;
		if (cfg.hip_limit != '0 && sampled_run_count_q >= cfg.hip_limit) begin
			result.sampled_hip_hit = 1'b0;
		end
		if (cfg.hip_limit != '0 && or_run_count_q >= cfg.hip_limit) begin
			result.or_hip_hit = 1'b0;
		end
	end

	// Step state, advanced once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_step_q         <= '0;
			prev_comp_q         <= 1'b0;
			sampled_flag_q      <= 1'b0;
			latched_pending_q   <= 1'b0;
			latched_current_q   <= 1'b0;
			sampled_run_count_q <= '0;
			or_run_count_q      <= '0;
		end else if (step_en) begin
			prev_comp_q <= comp;
			if (emit) begin
				fine_step_q       <= '0;
				sampled_flag_q    <= 1'b0;
				latched_pending_q <= 1'b0;
				latched_current_q <= pending_next;
				// Run counters count up while hits continue, saturating at CNT_MAX, and clear otherwise.
				if (!samp_now) begin
					sampled_run_count_q <= '0;
				end else if (sampled_run_count_q != CNT_MAX) begin
					sampled_run_count_q <= sampled_run_count_q + CNT_W'(1);
				end
				if (!or_now) begin
					or_run_count_q <= '0;
				end else if (or_run_count_q != CNT_MAX) begin
					or_run_count_q <= or_run_count_q + CNT_W'(1);
				end
			end else begin
				fine_step_q       <= fine_step_q + STEP_W'(1);
				sampled_flag_q    <= samp_now;
				latched_pending_q <= pending_next;
			end
		end
	end

`ifndef SYNTH
	// The fine-step counter never leaves one bunch clock.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fine_step_q) < STEPS_PER_CLOCK)
		else $error("fine step out of range");

	// An OR run can never be shorter than the sampled run it contains.
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		or_run_count_q >= sampled_run_count_q)
		else $error("OR run count below sampled run count");

	// A captured edge is reported in the following clock.
	a_latch_move: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && emit && edge_hit |=> latched_current_q)
		else $error("edge at last step not carried into next clock");
`endif

endmodule
